FILE: src/vtps_pkg.sv
package vtps_pkg;

  // Dividend width of the shared quotient pipeline: the largest numerator
  // is (row + 720) * 65535, which needs 29 bits.
  localparam int unsigned NUM_W = 29;

  // Pattern modes.
  localparam logic [2:0] MODE_RGBA   = 3'd1;
  localparam logic [2:0] MODE_STEP8  = 3'd2;
  localparam logic [2:0] MODE_RAMP16 = 3'd3;
  localparam logic [2:0] MODE_GRID8  = 3'd4;
  localparam logic [2:0] MODE_GRID10 = 3'd5;
  localparam logic [2:0] MODE_SCROLL = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  // Plane codes.
  localparam logic [1:0] PLANE_LUMA = 2'd0;
  localparam logic [1:0] PLANE_CB   = 2'd1;
  localparam logic [1:0] PLANE_CR   = 2'd2;

  // How the final stage forms the sample.
  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0,
    KIND_STEP8  = 2'd1,
    KIND_Q16    = 2'd2,
    KIND_INV16  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        present;
  } side_t;

endpackage

FILE: src/vtps_if.sv
interface vtps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  plane;
  logic [11:0] col;
  logic [11:0] row;
  logic [15:0] frame_index;

  modport source (output valid, output plane, output col, output row,
                  output frame_index, input ready);
  modport sink (input valid, input plane, input col, input row,
                input frame_index, output ready);
endinterface

interface vtps_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample;
  logic        plane_present;

  modport source (output valid, output sample, output plane_present, input ready);
  modport sink (input valid, input sample, input plane_present, output ready);
endinterface

FILE: src/vtps_div_stage.sv
module vtps_div_stage
  import vtps_pkg::*;
#(
  parameter int unsigned DW = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DW-1:0]    in_rem,
  input  logic [NUM_W-1:0] in_nq,
  input  logic [DW-1:0]    in_d,
  input  side_t            in_side,
  output logic             out_valid_r,
  output logic [DW-1:0]    out_rem_r,
  output logic [NUM_W-1:0] out_nq_r,
  output logic [DW-1:0]    out_d_r,
  output side_t            out_side_r
);

  logic [DW:0]    trial;
  logic           ge;
  logic [DW-1:0]  rem_nxt;
  logic [DW:0]    diff;

  // One restoring step: bring down the next dividend bit and try the divisor.
  always_comb begin
    trial   = {in_rem, in_nq[NUM_W-1]};
    ge      = (trial >= {1'b0, in_d});
    diff    = trial - {1'b0, in_d};
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  // The quotient bits shift in from the bottom as the dividend shifts out.
  always_ff @(posedge clk) begin
    if (en) begin
      out_rem_r  <= rem_nxt;
      out_nq_r   <= {in_nq[NUM_W-2:0], ge};
      out_d_r    <= in_d;
      out_side_r <= in_side;
    end
  end

endmodule

FILE: src/video_test_pattern_sample.sv
// An accepted input beat passes stages 0 to 2, the 29-stage quotient pipeline
// (one quotient bit per stage) and the output register. Throughput: one beat per
// cycle unless out_m.ready holds the output; every stage moves on its own.
// Reset (rst_n, synchronous, active low) empties the pipeline and sets
// pattern_mode to 5, frame_width to 1280 and frame_height to 720.
module video_test_pattern_sample
  import vtps_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  vtps_in_if.sink     in_s,
  vtps_out_if.source  out_m
);

  localparam int unsigned DW = $clog2(MAX_DIM + 4096);

  // Configuration registers.
  logic [2:0]    mode_r;
  logic [12:0]   width_r;
  logic [12:0]   height_r;
  logic [DW-1:0] w_eff_r;
  logic [DW-1:0] h_eff_r;
  logic [DW-1:0] w_eff_nxt;
  logic [DW-1:0] h_eff_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 3'd5;
      width_r  <= 13'd1280;
      height_r <= 13'd720;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_data[2:0];
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the dimensions into 2 .. MAX_DIM.
  always_comb begin
    if (width_r < 13'd2) begin
      w_eff_nxt = DW'(2);
    end else if (32'(width_r) > MAX_DIM) begin
      w_eff_nxt = DW'(MAX_DIM);
    end else begin
      w_eff_nxt = DW'(width_r);
    end
    if (height_r < 13'd2) begin
      h_eff_nxt = DW'(2);
    end else if (32'(height_r) > MAX_DIM) begin
      h_eff_nxt = DW'(MAX_DIM);
    end else begin
      h_eff_nxt = DW'(height_r);
    end
  end

  always_ff @(posedge clk) begin
    w_eff_r <= w_eff_nxt;
    h_eff_r <= h_eff_nxt;
  end

  // Stage enables: a stage moves when it is empty or its successor moves.
  localparam int unsigned NSTG = NUM_W;
  logic            en0, en1, en2, en_o;
  logic [NSTG-1:0] en_d;
  logic [NSTG-1:0] dv;
  logic            v0_r, v1_r, v2_r, out_v_r;

  assign en_o = !out_v_r || out_m.ready;
  assign en_d[NSTG-1] = !dv[NSTG-1] || en_o;
  for (genvar i = 0; i < NSTG - 1; i++) begin : g_en
    assign en_d[i] = !dv[i] || en_d[i+1];
  end
  assign en2 = !v2_r || en_d[0];
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;
  assign in_s.ready = en0;

  // Stage 0: capture the beat with the diagonal sum and distance.
  logic [1:0]  p0_plane_r;
  logic [11:0] p0_x_r, p0_y_r;
  logic [15:0] p0_fi_r;
  logic [12:0] p0_s_r;
  logic [11:0] p0_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en0) begin
      v0_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      p0_plane_r <= in_s.plane;
      p0_x_r     <= in_s.col;
      p0_y_r     <= in_s.row;
      p0_fi_r    <= in_s.frame_index;
      p0_s_r     <= 13'(in_s.col) + 13'(in_s.row);
      p0_d_r     <= (in_s.col >= in_s.row) ? in_s.col - in_s.row : in_s.row - in_s.col;
    end
  end

  // Stage 1: quotients by 5 and 9 through reciprocal multiplication.
  logic [1:0]  p1_plane_r;
  logic [11:0] p1_x_r, p1_y_r;
  logic [15:0] p1_fi_r;
  logic [12:0] p1_s_r;
  logic [11:0] p1_d_r;
  logic [8:0]  p1_qs_r;
  logic [7:0]  p1_qd_r;
  logic [9:0]  p1_qf_r;
  logic [25:0] prod_s, prod_d, prod_f;

  always_comb begin
    prod_s = 26'(p0_s_r[12:2]) * 26'd13108;
    prod_d = 26'(p0_d_r[11:2]) * 26'd13108;
    prod_f = 26'(p0_fi_r[15:3]) * 26'd7282;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p1_plane_r <= p0_plane_r;
      p1_x_r     <= p0_x_r;
      p1_y_r     <= p0_y_r;
      p1_fi_r    <= p0_fi_r;
      p1_s_r     <= p0_s_r;
      p1_d_r     <= p0_d_r;
      p1_qs_r    <= prod_s[24:16];
      p1_qd_r    <= prod_d[23:16];
      p1_qf_r    <= prod_f[25:16];
    end
  end

  // Stage 2: residues, grid values, scroll offset and divider operands.
  logic [10:0]      rs_full;
  logic [9:0]       rd_full;
  logic [12:0]      rf_full;
  logic [4:0]       m20s, m20d;
  logic [3:0]       m10s, m10d;
  logic [6:0]       fm72;
  logic [9:0]       shift;
  logic [12:0]      yy;
  logic [8:0]       grid_v;
  logic             chroma_line;
  logic [NUM_W-1:0] num_nxt;
  logic [DW-1:0]    den_nxt;
  side_t            side_nxt;
  logic [NUM_W-1:0] p2_num_r;
  logic [DW-1:0]    p2_den_r;
  side_t            p2_side_r;

  always_comb begin
    rs_full = p1_s_r[12:2] - 11'(p1_qs_r * 4'd5);
    rd_full = p1_d_r[11:2] - 10'(p1_qd_r * 4'd5);
    rf_full = p1_fi_r[15:3] - 13'(p1_qf_r * 4'd9);
    m20s = {rs_full[2:0], p1_s_r[1:0]};
    m20d = {rd_full[2:0], p1_d_r[1:0]};
    m10s = (m20s >= 5'd10) ? 4'(m20s - 5'd10) : m20s[3:0];
    m10d = (m20d >= 5'd10) ? 4'(m20d - 5'd10) : m20d[3:0];
    // frame_index mod 72, then the scroll offset 720 - 10 * that.
    fm72  = {rf_full[3:0], p1_fi_r[2:0]};
    shift = 10'd720 - 10'(fm72 * 4'd10);
    yy    = 13'(p1_y_r) + 13'(shift);
    chroma_line = (m10s == 4'd0) || (m10d == 4'd0);

    if (p1_plane_r == PLANE_LUMA) begin
      if (m20s == 5'd0 || m20d == 5'd0) begin
        grid_v = 9'd82;
      end else if (m20s == 5'd1 || m20d == 5'd1 || m20s == 5'd19 || m20d == 5'd19) begin
        grid_v = 9'd49;
      end else begin
        grid_v = 9'd16;
      end
    end else if (p1_plane_r == PLANE_CB) begin
      grid_v = chroma_line ? 9'd90 : 9'd128;
    end else begin
      grid_v = chroma_line ? 9'd240 : 9'd128;
    end

    num_nxt = '0;
    den_nxt = DW'(1);
    side_nxt.kind    = KIND_DIRECT;
    side_nxt.value   = '0;
    side_nxt.present = 1'b0;

    if (p1_plane_r != 2'd3) begin
      unique case (mode_r)
        MODE_RGBA: begin
          if (p1_plane_r == PLANE_LUMA) begin
            side_nxt.present = 1'b1;
            side_nxt.value   = {8'h00, 8'hFF, p1_y_r[7:0], p1_x_r[7:0]};
          end
        end
        MODE_STEP8: begin
          side_nxt.present = 1'b1;
          if (p1_plane_r == PLANE_LUMA) begin
            side_nxt.kind = KIND_STEP8;
            num_nxt = NUM_W'({p1_x_r, 8'h00} - 20'(p1_x_r));
            den_nxt = w_eff_r + DW'(p1_y_r) - DW'(1);
          end else begin
            side_nxt.value = 32'd128;
          end
        end
        MODE_RAMP16, MODE_SCROLL: begin
          side_nxt.present = 1'b1;
          if (p1_plane_r == PLANE_LUMA) begin
            side_nxt.value = 32'd32768;
          end else if (p1_plane_r == PLANE_CB) begin
            side_nxt.kind = KIND_Q16;
            num_nxt = NUM_W'({p1_x_r, 16'h0000} - 28'(p1_x_r));
            den_nxt = w_eff_r - DW'(1);
          end else if (mode_r == MODE_RAMP16) begin
            side_nxt.kind = KIND_INV16;
            num_nxt = NUM_W'({p1_y_r, 16'h0000} - 28'(p1_y_r));
            den_nxt = h_eff_r - DW'(1);
          end else begin
            side_nxt.kind = KIND_INV16;
            num_nxt = {yy, 16'h0000} - NUM_W'(yy);
            den_nxt = DW'(719);
          end
        end
        MODE_GRID8, MODE_GRID10: begin
          side_nxt.present = 1'b1;
          side_nxt.value = (mode_r == MODE_GRID10) ? {21'd0, grid_v, 2'b00}
                                                   : {23'd0, grid_v};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      p2_num_r  <= num_nxt;
      p2_den_r  <= den_nxt;
      p2_side_r <= side_nxt;
    end
  end

  // Quotient pipeline: one bit per stage.
  logic [DW-1:0]    drem [NSTG];
  logic [NUM_W-1:0] dnq  [NSTG];
  logic [DW-1:0]    dden [NSTG];
  side_t            dside[NSTG];

  for (genvar i = 0; i < NSTG; i++) begin : g_div
    if (i == 0) begin : g_first
      vtps_div_stage #(.DW(DW)) u_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en_d[i]),
        .in_valid   (v2_r),
        .in_rem     ('0),
        .in_nq      (p2_num_r),
        .in_d       (p2_den_r),
        .in_side    (p2_side_r),
        .out_valid_r(dv[i]),
        .out_rem_r  (drem[i]),
        .out_nq_r   (dnq[i]),
        .out_d_r    (dden[i]),
        .out_side_r (dside[i])
      );
    end else begin : g_rest
      vtps_div_stage #(.DW(DW)) u_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en_d[i]),
        .in_valid   (dv[i-1]),
        .in_rem     (drem[i-1]),
        .in_nq      (dnq[i-1]),
        .in_d       (dden[i-1]),
        .in_side    (dside[i-1]),
        .out_valid_r(dv[i]),
        .out_rem_r  (drem[i]),
        .out_nq_r   (dnq[i]),
        .out_d_r    (dden[i]),
        .out_side_r (dside[i])
      );
    end
  end

  // Output register: form the sample from the quotient or the direct value.
  logic [NUM_W-1:0] quo;
  logic [31:0]      sample_nxt;
  logic [31:0]      sample_r;
  logic             present_r;

  always_comb begin
    quo = dnq[NSTG-1];
    unique case (dside[NSTG-1].kind)
      KIND_DIRECT: sample_nxt = dside[NSTG-1].value;
      KIND_STEP8:  sample_nxt = {24'd0, quo[7:3], 3'b000};
      KIND_Q16:    sample_nxt = {16'd0, quo[15:0]};
      KIND_INV16:  sample_nxt = {16'd0, ~quo[15:0]};
      default:     sample_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_o) begin
      out_v_r <= dv[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      sample_r  <= sample_nxt;
      present_r <= dside[NSTG-1].present;
    end
  end

  assign out_m.valid         = out_v_r;
  assign out_m.sample        = sample_r;
  assign out_m.plane_present = present_r;

endmodule

FILE: verif/video_test_pattern_sample_checker.sv
module video_test_pattern_sample_checker
  import vtps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_plane,
  input  logic [11:0] in_col,
  input  logic [11:0] in_row,
  input  logic [15:0] in_frame_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_sample,
  input  logic        out_plane_present,
  output int          mismatches,
  output int          pending,
  output int          beats_checked
);

  typedef struct packed {
    logic [31:0] sample;
    logic        present;
  } pattern_beat_t;

  pattern_beat_t expected_beats[$];
  logic [2:0]  mode_q;
  logic [12:0] width_q;
  logic [12:0] height_q;

  function automatic logic [31:0] udiff(logic [31:0] a, logic [31:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [31:0] clamp_dim(logic [12:0] v);
    if (v < 13'd2) return 32'd2;
    if (v > 13'd4096) return 32'd4096;
    return 32'(v);
  endfunction

  // Works out the sample that one input beat should give under the current settings.
  function automatic pattern_beat_t pattern_value(logic [1:0] plane, logic [11:0] col,
                                                  logic [11:0] row, logic [15:0] fi);
    pattern_beat_t r;
    logic [63:0] x, y, w, h, yy, q;
    logic [31:0] s20, d20, v, shift;
    logic line;
    x = 64'(col); y = 64'(row);
    w = 64'(clamp_dim(width_q)); h = 64'(clamp_dim(height_q));
    r = '0;
    if (plane <= 2 && mode_q >= MODE_RGBA && mode_q <= MODE_SCROLL) begin
      r.present = 1'b1;
      case (mode_q)
        MODE_RGBA: begin
          if (plane == PLANE_LUMA) r.sample = {8'h00, 8'hFF, row[7:0], col[7:0]};
          else r.present = 1'b0;
        end
        MODE_STEP8: begin
          if (plane == PLANE_LUMA) begin
            q = (x * 255) / (w + y - 1);
            r.sample = 32'((q / 8 * 8) & 64'hFF);
          end else begin
            r.sample = 128;
          end
        end
        MODE_RAMP16, MODE_SCROLL: begin
          if (plane == PLANE_LUMA) r.sample = 32768;
          else if (plane == PLANE_CB) r.sample = 32'(((x * 65535) / (w - 1)) & 64'hFFFF);
          else if (mode_q == MODE_RAMP16)
            r.sample = 32'((65535 - (y * 65535) / (h - 1)) & 64'hFFFF);
          else begin
            shift = 720 - (32'(fi) * 10) % 720;
            yy = y + 64'(shift);
            r.sample = 32'((65535 - (yy * 65535) / 719) & 64'hFFFF);
          end
        end
        default: begin
          s20 = (32'(col) + 32'(row)) % 20;
          d20 = udiff(32'(col), 32'(row)) % 20;
          line = ((32'(col) + 32'(row)) % 10 == 0) || (udiff(32'(col), 32'(row)) % 10 == 0);
          if (plane == PLANE_LUMA) begin
            if (s20 == 0 || d20 == 0) v = 82;
            else if (s20 == 1 || d20 == 1 || s20 == 19 || d20 == 19) v = 49;
            else v = 16;
          end else if (plane == PLANE_CB) v = line ? 90 : 128;
          else v = line ? 240 : 128;
          r.sample = (mode_q == MODE_GRID10) ? v * 4 : v;
        end
      endcase
    end
    return r;
  endfunction

  // Shadow registers, expectation store and comparison of each result beat.
  always @(posedge clk) begin
    pattern_beat_t got, want;
    if (!rst_n) begin
      mode_q <= MODE_GRID10;
      width_q <= 13'd1280;
      height_q <= 13'd720;
      expected_beats.delete();
      mismatches <= 0;
      beats_checked <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_beats.push_back(pattern_value(in_plane, in_col, in_row, in_frame_index));
      if (out_valid && out_ready) begin
        got.sample = out_sample;
        got.present = out_plane_present;
        beats_checked <= beats_checked + 1;
        if (expected_beats.size() == 0) begin
          if (mismatches < 10) $display("unexpected result beat: %h %b", out_sample,
                                        out_plane_present);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_beats.pop_front();
          if (want != got) begin
            if (mismatches < 10)
              $display("mismatch: expected sample %h present %b, got sample %h present %b",
                       want.sample, want.present, got.sample, got.present);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:   mode_q <= cfg_data[2:0];
          CFG_WIDTH:  width_q <= cfg_data;
          CFG_HEIGHT: height_q <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign pending = expected_beats.size();

endmodule

FILE: verif/video_test_pattern_sample_tb.sv
module video_test_pattern_sample_tb;
  import vtps_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_MODE;
  logic [12:0] cfg_data = '0;
  int mismatches, pending, beats_checked;
  int cycle_count = 0;
  int hold_req = 0;
  int hold_done = 0;
  int stall_left = 0;
  int beats_sent = 0;

  vtps_in_if in_ch ();
  vtps_out_if out_ch ();

  always #4 clk = ~clk;

  video_test_pattern_sample dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_s(in_ch.sink), .out_m(out_ch.source)
  );

  video_test_pattern_sample_checker checker_i (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_plane(in_ch.plane), .in_col(in_ch.col), .in_row(in_ch.row),
    .in_frame_index(in_ch.frame_index), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_sample(out_ch.sample),
    .out_plane_present(out_ch.plane_present), .mismatches(mismatches),
    .pending(pending), .beats_checked(beats_checked)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Receiver: random gaps, plus one long hold-off when asked for.
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_done) begin
      out_ch.ready <= 1'b0;
      hold_done <= hold_req;
      stall_left <= 300;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      w = gap_len();
      if (w == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left <= w - 1;
      end
    end
  end

  // Valid stays high between back-to-back beats and drops only for a gap or a drain.
  task automatic send_beat(logic [1:0] p, logic [11:0] c, logic [11:0] r, logic [15:0] f);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.plane <= p;
    in_ch.col <= c;
    in_ch.row <= r;
    in_ch.frame_index <= f;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_beat();
    logic [1:0] p;
    logic [11:0] c, r;
    p = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    c = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 300));
    r = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 300));
    send_beat(p, c, r, 16'($urandom));
  endtask

  // Stimulus: directed corners first, then random phases over many settings.
  initial begin
    logic [12:0] dims[6];
    dims = '{13'd0, 13'd2, 13'd1280, 13'd4096, 13'd8191, 13'd5000};
    in_ch.valid = 1'b0;
    in_ch.plane = '0;
    in_ch.col = '0;
    in_ch.row = '0;
    in_ch.frame_index = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Reset settings, grid mode 5.
    send_beat(PLANE_LUMA, 12'd0, 12'd0, 16'd0);
    send_beat(PLANE_LUMA, 12'd4095, 12'd4095, 16'hFFFF);
    send_beat(PLANE_CB, 12'd10, 12'd0, 16'd0);
    send_beat(PLANE_CR, 12'd1, 12'd0, 16'd0);
    send_beat(2'd3, 12'd5, 12'd5, 16'd0);
    drain();
    for (int m = 0; m <= 7; m++) begin
      write_reg(CFG_MODE, 13'(m));
      send_beat(PLANE_LUMA, 12'd4095, 12'd0, 16'hFFFF);
      send_beat(PLANE_CB, 12'd4095, 12'd4095, 16'd0);
      send_beat(PLANE_CR, 12'd0, 12'd4095, 16'd72);
      drain();
    end
    // Long hold-off on the receiver while the sender keeps offering beats.
    write_reg(CFG_MODE, 13'(MODE_SCROLL));
    hold_req <= hold_req + 1;
    for (int i = 0; i < 80; i++) random_beat();
    drain();
    for (int ph = 0; ph < 28; ph++) begin
      write_reg(CFG_MODE, 13'($urandom_range(0, 7)));
      write_reg(CFG_WIDTH,
                dims[$urandom_range(0, 5)] ^ ($urandom_range(0, 1) ? 13'($urandom) : 13'd0));
      write_reg(CFG_HEIGHT,
                dims[$urandom_range(0, 5)] ^ ($urandom_range(0, 1) ? 13'($urandom) : 13'd0));
      for (int i = 0; i < 45; i++) random_beat();
      drain();
    end
    $display("Sent %0d beats and checked %0d results across all modes, invalid modes,",
             beats_sent, beats_checked);
    $display("missing planes and clamped frame sizes, with stalls on both sides.");
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
